@@ src/vhdma_pkg.sv @@
// Shared types and constants for the VRAM DMA controller.
// Used by vhdma_res_fifo and vram_general_hblank_dma_controller_top; no dependencies.
`default_nettype none
package vhdma_pkg;

	localparam logic [1:0] FUNC_WRITE  = 2'd0;
	localparam logic [1:0] FUNC_READ   = 2'd1;
	localparam logic [1:0] FUNC_TICK   = 2'd2;
	localparam logic [1:0] FUNC_HBLANK = 2'd3;

	localparam logic [2:0] REG_SRC_HI = 3'd0;
	localparam logic [2:0] REG_SRC_LO = 3'd1;
	localparam logic [2:0] REG_DST_HI = 3'd2;
	localparam logic [2:0] REG_DST_LO = 3'd3;
	localparam logic [2:0] REG_CTRL   = 3'd4;

	localparam logic [7:0]  RDATA_NONE = 8'hFF;
	localparam logic [11:0] BLOCK_BYTES = 12'd16;

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic [7:0]  rdata;
		logic        copy_valid;
		logic [15:0] src_addr;
		logic [12:0] dst_offset;
		logic        dst_bank;
		logic        transfer_active;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

endpackage
`default_nettype wire

@@ src/vhdma_res_fifo.sv @@
// Small result queue between the DMA state logic and the output channel.
// Takes one or two results per push; depends on vhdma_pkg.
`default_nettype none
module vhdma_res_fifo
	import vhdma_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire push_t            push,
	output logic                  room,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output res_t                  head
);

	res_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pop;
	logic [PTR_W-1:0] wr_p1;

	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && !out_stall;
	assign head      = mem_q[rd_q];
	// two free slots must remain for a two-copy tick
	assign room      = (cnt_q <= CNT_W'(FIFO_DEPTH - 2));
	assign wr_p1     = wr_q + PTR_W'(1);

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_p1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PTR_W'(push.n);
			if (pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + CNT_W'(push.n) - CNT_W'(pop);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(FIFO_DEPTH))
		else $error("result queue overfilled");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n != 2'd0) |-> room)
		else $error("push without room");

	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> cnt_q == $past(cnt_q) + CNT_W'($past(push.n)) - CNT_W'($past(pop)))
		else $error("queue count out of step");

endmodule
`default_nettype wire

@@ src/vram_general_hblank_dma_controller_top.sv @@
// VRAM DMA controller: staging latches, general/HBlank transfer state, copy commands.
// Results of an accepted item are registered in the result queue before they are offered.
// Throughput: one item per cycle while the input is not stalled; a two-copy tick puts two results on the output.
// The input stalls only when the 4-entry result queue lacks room for two results.
// Reset (arst_n low) clears all transfer state and latches; cgb_mode comes up 1.
// Depends on vhdma_pkg and vhdma_res_fifo.
`default_nettype none
module vram_general_hblank_dma_controller_top
	import vhdma_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic        cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  func,
	input  wire logic [2:0]  reg_index,
	input  wire logic [7:0]  wdata,
	input  wire logic        double_speed,
	input  wire logic        cpu_halted,
	input  wire logic        vram_bank,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       rdata,
	output logic             copy_valid,
	output logic [15:0]      src_addr,
	output logic [12:0]      dst_offset,
	output logic             dst_bank,
	output logic             transfer_active,
	output logic             last
);

	logic [7:0]  latch_q [4];
	logic [15:0] src_q;
	logic [12:0] dst_q;
	logic [11:0] rem_q;
	logic [11:0] bbl_q;
	logic        hblank_q;
	logic        active_q;
	logic        cgb_q;

	logic [15:0] src_n;
	logic [12:0] dst_n;
	logic [11:0] rem_n;
	logic [11:0] bbl_n;
	logic        hblank_n;
	logic        active_n;

	logic        accept;
	logic        room;
	push_t       push;
	res_t        head;

	logic [11:0] rem1, rem2, bbl1;
	logic        act0, act1, two_copies, cancel;
	logic [7:0]  arm_blocks;
	logic [6:0]  status_blocks;

	assign in_stall = !room;
	assign accept   = in_valid && !in_stall;

	assign rem1          = rem_q - 12'd1;
	assign rem2          = rem_q - 12'd2;
	assign bbl1          = bbl_q - 12'd1;
	assign act0          = active_q && (rem1 != '0);
	assign act1          = act0 && (rem2 != '0);
	assign two_copies    = !(cgb_q && double_speed) && (bbl1 != '0);
	assign cancel        = active_q && hblank_q && !wdata[7];
	assign arm_blocks    = {1'b0, wdata[6:0]} + 8'd1;
	assign status_blocks = rem_q[10:4] - 7'd1;

	always_comb begin
		src_n    = src_q;
		dst_n    = dst_q;
		rem_n    = rem_q;
		bbl_n    = bbl_q;
		hblank_n = hblank_q;
		active_n = active_q;
		push     = '0;
		push.n   = accept ? 2'd1 : 2'd0;
		push.r0.last            = 1'b1;
		push.r0.transfer_active = active_q;
		push.r1.last            = 1'b1;
		unique case (func)
			FUNC_WRITE: begin
				if (cgb_q && reg_index == REG_CTRL) begin
					if (cancel) begin
						active_n = 1'b0;
					end else begin
						src_n    = {latch_q[REG_SRC_HI[1:0]], latch_q[REG_SRC_LO[1:0]][7:4], 4'h0};
						dst_n    = {latch_q[REG_DST_HI[1:0]][4:0],
							latch_q[REG_DST_LO[1:0]][7:4], 4'h0};
						rem_n    = {arm_blocks, 4'h0};
						hblank_n = wdata[7];
						active_n = 1'b1;
						bbl_n    = wdata[7] ? 12'd0 : {arm_blocks, 4'h0};
					end
				end
				push.r0.transfer_active = active_n;
			end
			FUNC_READ: begin
				if (!cgb_q || reg_index != REG_CTRL) begin
					push.r0.rdata = RDATA_NONE;
				end else if (active_q) begin
					push.r0.rdata = {1'b0, status_blocks};
				end else if (rem_q != '0) begin
					push.r0.rdata = {1'b1, status_blocks};
				end else begin
					push.r0.rdata = RDATA_NONE;
				end
			end
			FUNC_HBLANK: begin
				// in CGB mode, release the next block of an active HBlank transfer unless halted or a block is still open
				if (cgb_q && active_q && hblank_q && bbl_q == '0 && !cpu_halted) begin
					bbl_n = (rem_q < BLOCK_BYTES) ? rem_q : BLOCK_BYTES;
				end
			end
			FUNC_TICK: begin
				if (bbl_q != '0) begin
					push.r0.copy_valid      = 1'b1;
					push.r0.src_addr        = src_q;
					push.r0.dst_offset      = dst_q;
					push.r0.dst_bank        = vram_bank;
					push.r0.transfer_active = act0;
					push.r0.last            = !two_copies;
					push.r1.copy_valid      = 1'b1;
					push.r1.src_addr        = src_q + 16'd1;
					push.r1.dst_offset      = dst_q + 13'd1;
					push.r1.dst_bank        = vram_bank;
					push.r1.transfer_active = act1;
					if (two_copies) begin
						push.n   = accept ? 2'd2 : 2'd0;
						src_n    = src_q + 16'd2;
						dst_n    = dst_q + 13'd2;
						rem_n    = rem2;
						bbl_n    = bbl_q - 12'd2;
						active_n = act1;
					end else begin
						src_n    = src_q + 16'd1;
						dst_n    = dst_q + 13'd1;
						rem_n    = rem1;
						bbl_n    = bbl1;
						active_n = act0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				latch_q[i] <= '0;
			end
			src_q    <= '0;
			dst_q    <= '0;
			rem_q    <= '0;
			bbl_q    <= '0;
			hblank_q <= 1'b0;
			active_q <= 1'b0;
			cgb_q    <= 1'b1;
		end else begin
			if (cfg_wr_en) begin
				cgb_q <= cfg_wr_data;
			end
			if (accept) begin
				if (func == FUNC_WRITE && cgb_q && !reg_index[2]) begin
					latch_q[reg_index[1:0]] <= wdata;
				end
				src_q    <= src_n;
				dst_q    <= dst_n;
				rem_q    <= rem_n;
				bbl_q    <= bbl_n;
				hblank_q <= hblank_n;
				active_q <= active_n;
			end
		end
	end

	vhdma_res_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign rdata           = head.rdata;
	assign copy_valid      = head.copy_valid;
	assign src_addr        = head.src_addr;
	assign dst_offset      = head.dst_offset;
	assign dst_bank        = head.dst_bank;
	assign transfer_active = head.transfer_active;
	assign last            = head.last;

	a_block_within_total: assert property (@(posedge clk) disable iff (!arst_n)
		bbl_q <= rem_q)
		else $error("released block exceeds remaining length");

	a_active_needs_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> rem_q != '0)
		else $error("active transfer with nothing remaining");

	a_tick_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && func == FUNC_TICK && bbl_q != '0) |=> rem_q != $past(rem_q))
		else $error("tick with open block did not advance");

endmodule
`default_nettype wire
